// File: src/slpe_pkg.sv
// Shared constants, types and tables of the status LED pattern engine.
`timescale 1ns / 1ps
`default_nettype none
package slpe_pkg;

  localparam int ELAPSED_W = 10;
  localparam int COUNT_W   = 11;
  localparam int FRAME_W   = 8;
  localparam int COLOR_W   = 8;
  localparam int MODE_W    = 3;
  localparam int INTV_W    = 9;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

  localparam logic [MODE_W-1:0] MODE_SOLID   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_BLINK   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PULSE   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RAINBOW = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CHASE   = 3'd4;

  localparam logic [INTV_W-1:0] INTV_NONE    = 9'd0;
  localparam logic [INTV_W-1:0] INTV_BLINK   = 9'd500;
  localparam logic [INTV_W-1:0] INTV_PULSE   = 9'd50;
  localparam logic [INTV_W-1:0] INTV_RAINBOW = 9'd50;
  localparam logic [INTV_W-1:0] INTV_CHASE   = 9'd100;

  localparam logic [REG_IDX_W-1:0] REG_PATTERN = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_RED     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_GREEN   = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_BLUE    = 2'd3;

  localparam logic [FRAME_W:0]   PULSE_FRAMES = 9'd100;
  localparam logic [FRAME_W-1:0] PULSE_STEP   = 8'd2;
  localparam logic [FRAME_W-1:0] RAINBOW_STEP = 8'd2;
  localparam logic [FRAME_W-1:0] CHASE_LAST   = 8'd9;

  localparam logic [COLOR_W-1:0] WHEEL_THIRD    = 8'd85;
  localparam logic [COLOR_W-1:0] WHEEL_TWOTHIRD = 8'd170;
  localparam logic [COLOR_W-1:0] COLOR_FULL     = 8'd255;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic              clear;
    logic [MODE_W-1:0] mode;
    rgb_t              color;
  } cfg_t;

  // Sine scale, one entry per even pulse frame.
  function automatic logic [COLOR_W-1:0] sine_scale(input logic [5:0] idx);
    logic [COLOR_W-1:0] s;
    case (idx)
      6'd0:  s = 8'd128;  6'd1:  s = 8'd144;  6'd2:  s = 8'd159;  6'd3:  s = 8'd175;
      6'd4:  s = 8'd189;  6'd5:  s = 8'd203;  6'd6:  s = 8'd215;  6'd7:  s = 8'd226;
      6'd8:  s = 8'd236;  6'd9:  s = 8'd243;  6'd10: s = 8'd249;  6'd11: s = 8'd253;
      6'd12: s = 8'd255;  6'd13: s = 8'd255;  6'd14: s = 8'd253;  6'd15: s = 8'd249;
      6'd16: s = 8'd243;  6'd17: s = 8'd236;  6'd18: s = 8'd226;  6'd19: s = 8'd215;
      6'd20: s = 8'd203;  6'd21: s = 8'd189;  6'd22: s = 8'd175;  6'd23: s = 8'd160;
      6'd24: s = 8'd144;  6'd25: s = 8'd128;  6'd26: s = 8'd112;  6'd27: s = 8'd96;
      6'd28: s = 8'd81;   6'd29: s = 8'd66;   6'd30: s = 8'd52;   6'd31: s = 8'd40;
      6'd32: s = 8'd29;   6'd33: s = 8'd20;   6'd34: s = 8'd12;   6'd35: s = 8'd6;
      6'd36: s = 8'd2;    6'd37: s = 8'd0;    6'd38: s = 8'd0;    6'd39: s = 8'd2;
      6'd40: s = 8'd6;    6'd41: s = 8'd12;   6'd42: s = 8'd19;   6'd43: s = 8'd29;
      6'd44: s = 8'd40;   6'd45: s = 8'd52;   6'd46: s = 8'd66;   6'd47: s = 8'd80;
      6'd48: s = 8'd95;   6'd49: s = 8'd111;
      default: s = 8'd0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// File: src/slpe_regs.sv
// Configuration register file with its APB-style access port.
`timescale 1ns / 1ps
`default_nettype none
module slpe_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [slpe_pkg::ADDR_W-1:0] paddr,
  input  logic [slpe_pkg::DATA_W-1:0] pwdata,
  output logic [slpe_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output slpe_pkg::cfg_t              cfg
);
  import slpe_pkg::*;

  logic                 wr;
  logic [REG_IDX_W-1:0] reg_idx;
  logic [MODE_W-1:0]    mode;
  rgb_t                 color;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_SOLID;
      color <= '0;
    end else if (wr) begin
      case (reg_idx)
        REG_PATTERN: mode        <= pwdata[MODE_W-1:0];
        REG_RED:     color.red   <= pwdata[COLOR_W-1:0];
        REG_GREEN:   color.green <= pwdata[COLOR_W-1:0];
        REG_BLUE:    color.blue  <= pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PATTERN: prdata = {{(DATA_W-MODE_W){1'b0}}, mode};
      REG_RED:     prdata = {{(DATA_W-COLOR_W){1'b0}}, color.red};
      REG_GREEN:   prdata = {{(DATA_W-COLOR_W){1'b0}}, color.green};
      REG_BLUE:    prdata = {{(DATA_W-COLOR_W){1'b0}}, color.blue};
      default:     prdata = '0;
    endcase
  end

  // A pattern write restarts the animation in the same cycle.
  assign cfg.clear = wr && (reg_idx == REG_PATTERN);
  assign cfg.mode  = mode;
  assign cfg.color = color;

endmodule
`default_nettype wire

// File: src/slpe_frame.sv
// Next frame and frame colour for each animated pattern.
`timescale 1ns / 1ps
`default_nettype none
module slpe_frame (
  input  slpe_pkg::cfg_t               cfg,
  input  logic [slpe_pkg::FRAME_W-1:0] frame,
  output logic [slpe_pkg::FRAME_W-1:0] frame_next,
  output slpe_pkg::rgb_t               color_next
);
  import slpe_pkg::*;

  logic [FRAME_W:0]     pulse_sum;
  logic [FRAME_W-1:0]   pulse_frame;
  logic [COLOR_W-1:0]   scale;
  logic [2*COLOR_W-1:0] prod_r;
  logic [2*COLOR_W-1:0] prod_g;
  logic [2*COLOR_W-1:0] prod_b;
  logic [FRAME_W-1:0]   wheel_frame;
  logic [COLOR_W-1:0]   wp;
  logic [COLOR_W-1:0]   wq;
  logic [COLOR_W+1:0]   wq3_wide;
  logic [COLOR_W-1:0]   wq3;
  rgb_t                 wheel_color;
  logic [FRAME_W-1:0]   chase_frame;
  logic                 chase_lit;

  // Pulse: step by two, wrap at the table length.
  assign pulse_sum   = {1'b0, frame} + {1'b0, PULSE_STEP};
  assign pulse_frame = (pulse_sum >= PULSE_FRAMES) ? FRAME_W'(pulse_sum - PULSE_FRAMES)
                                                   : pulse_sum[FRAME_W-1:0];
  assign scale  = sine_scale(pulse_frame[6:1]);
  assign prod_r = cfg.color.red   * scale;
  assign prod_g = cfg.color.green * scale;
  assign prod_b = cfg.color.blue  * scale;

  // Rainbow: colour wheel of the reversed position.
  assign wheel_frame = frame + RAINBOW_STEP;
  assign wp          = ~wheel_frame;
  always_comb begin
    if (wp < WHEEL_THIRD) begin
      wq = wp;
    end else if (wp < WHEEL_TWOTHIRD) begin
      wq = wp - WHEEL_THIRD;
    end else begin
      wq = wp - WHEEL_TWOTHIRD;
    end
  end
  assign wq3_wide = {2'b00, wq} + {1'b0, wq, 1'b0};
  assign wq3      = wq3_wide[COLOR_W-1:0];
  always_comb begin
    if (wp < WHEEL_THIRD) begin
      wheel_color = '{red: COLOR_FULL - wq3, green: '0, blue: wq3};
    end else if (wp < WHEEL_TWOTHIRD) begin
      wheel_color = '{red: '0, green: wq3, blue: COLOR_FULL - wq3};
    end else begin
      wheel_color = '{red: wq3, green: COLOR_FULL - wq3, blue: '0};
    end
  end

  // Chase: count to ten, light on every third frame.
  assign chase_frame = (frame == CHASE_LAST) ? '0 : frame + 8'd1;
  always_comb begin
    case (chase_frame)
      8'd0, 8'd3, 8'd6, 8'd9: chase_lit = 1'b1;
      default:                chase_lit = 1'b0;
    endcase
  end

  always_comb begin
    frame_next = frame;
    color_next = '0;
    case (cfg.mode)
      MODE_BLINK: begin
        frame_next = (frame != '0) ? '0 : 8'd1;
        color_next = (frame != '0) ? rgb_t'('0) : cfg.color;
      end
      MODE_PULSE: begin
        frame_next = pulse_frame;
        color_next = '{red:   prod_r[2*COLOR_W-1:COLOR_W],
                       green: prod_g[2*COLOR_W-1:COLOR_W],
                       blue:  prod_b[2*COLOR_W-1:COLOR_W]};
      end
      MODE_RAINBOW: begin
        frame_next = wheel_frame;
        color_next = wheel_color;
      end
      MODE_CHASE: begin
        frame_next = chase_frame;
        color_next = chase_lit ? cfg.color : rgb_t'('0);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: src/slpe_engine.sv
// Time accumulator, frame state and result register with the item handshake.
`timescale 1ns / 1ps
`default_nettype none
module slpe_engine (
  input  logic                           clk,
  input  logic                           rst,
  input  slpe_pkg::cfg_t                 cfg,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic [slpe_pkg::ELAPSED_W-1:0] elapsed_ms,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [slpe_pkg::COLOR_W-1:0]   pixel_red,
  output logic [slpe_pkg::COLOR_W-1:0]   pixel_green,
  output logic [slpe_pkg::COLOR_W-1:0]   pixel_blue,
  output logic                           refresh
);
  import slpe_pkg::*;

  logic [COUNT_W-1:0] elapsed_count;
  logic [FRAME_W-1:0] frame_number;
  rgb_t               shown;
  logic [COUNT_W:0]   count_sum;
  logic [COUNT_W-1:0] count_sat;
  logic [INTV_W-1:0]  interval;
  logic               hit;
  logic               accept;
  logic [FRAME_W-1:0] frame_next;
  rgb_t               color_next;

  slpe_frame u_frame (
    .cfg        (cfg),
    .frame      (frame_number),
    .frame_next (frame_next),
    .color_next (color_next)
  );

  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  assign count_sum = {1'b0, elapsed_count} + {{(COUNT_W+1-ELAPSED_W){1'b0}}, elapsed_ms};
  assign count_sat = count_sum[COUNT_W] ? COUNT_MAX : count_sum[COUNT_W-1:0];

  always_comb begin
    case (cfg.mode)
      MODE_BLINK:   interval = INTV_BLINK;
      MODE_PULSE:   interval = INTV_PULSE;
      MODE_RAINBOW: interval = INTV_RAINBOW;
      MODE_CHASE:   interval = INTV_CHASE;
      default:      interval = INTV_NONE;
    endcase
  end

  assign hit = (interval != INTV_NONE) &&
               (count_sat >= {{(COUNT_W-INTV_W){1'b0}}, interval});

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_count <= '0;
      frame_number  <= '0;
      shown         <= '0;
      refresh       <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (cfg.clear) begin
        elapsed_count <= '0;
        frame_number  <= '0;
      end else if (accept) begin
        elapsed_count <= hit ? '0 : count_sat;
        if (hit) begin
          frame_number <= frame_next;
        end
      end
      if (accept) begin
        if (cfg.mode == MODE_SOLID) begin
          shown <= cfg.color;
        end else if (hit) begin
          shown <= color_next;
        end
        refresh <= hit;
      end
      // Hold the result until taken; a new transaction refills it.
      if (accept) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign pixel_red   = shown.red;
  assign pixel_green = shown.green;
  assign pixel_blue  = shown.blue;

endmodule
`default_nettype wire

// File: src/status_led_pattern_engine_core.sv
// Top level of the status LED pattern engine.
//
// Each accepted transaction carries the milliseconds elapsed since the last
// one and yields exactly one result in the next cycle: the colour now on the
// pixel and a refresh flag set when a pattern frame advanced. A new item is
// taken in every cycle, so the sustained rate is one item per clock; the
// input stalls only while a finished result waits in the output register
// and the consumer stalls it. The elapsed-time add and interval compare and
// the pulse scale multiply all feed the result register. Writing the
// pattern register restarts the animation at frame 0.
`timescale 1ns / 1ps
`default_nettype none
module status_led_pattern_engine_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [slpe_pkg::ADDR_W-1:0]    paddr,
  input  logic [slpe_pkg::DATA_W-1:0]    pwdata,
  output logic [slpe_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic [slpe_pkg::ELAPSED_W-1:0] elapsed_ms,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [slpe_pkg::COLOR_W-1:0]   pixel_red,
  output logic [slpe_pkg::COLOR_W-1:0]   pixel_green,
  output logic [slpe_pkg::COLOR_W-1:0]   pixel_blue,
  output logic                           refresh
);
  import slpe_pkg::*;

  cfg_t cfg;

  slpe_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  slpe_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .elapsed_ms   (elapsed_ms),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .pixel_red    (pixel_red),
    .pixel_green  (pixel_green),
    .pixel_blue   (pixel_blue),
    .refresh      (refresh)
  );

endmodule
`default_nettype wire

// File: src/slpe_checker.sv
// Port-level checks of the status LED pattern engine and their bind.
`timescale 1ns / 1ps
`default_nettype none
module slpe_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           item_valid,
  input logic                           item_stall,
  input logic                           result_valid,
  input logic                           result_stall,
  input logic [slpe_pkg::COLOR_W-1:0]   pixel_red,
  input logic [slpe_pkg::COLOR_W-1:0]   pixel_green,
  input logic [slpe_pkg::COLOR_W-1:0]   pixel_blue,
  input logic                           refresh
);

  // Drop any pending result on reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result pending after reset");

  // Input stalls only behind a full, stalled result register.
  a_stall_cause: assert property (@(posedge clk)
    item_stall |-> (result_valid && result_stall))
    else $error("input stalled without a blocked result");

  // Every accepted transaction leaves a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> result_valid)
    else $error("accepted item produced no result");

  // A stalled result holds its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=>
      (result_valid && $stable(pixel_red) && $stable(pixel_green) &&
       $stable(pixel_blue) && $stable(refresh)))
    else $error("stalled result changed");

endmodule

bind status_led_pattern_engine_core slpe_checker u_slpe_checker (.*);
`default_nettype wire

// File: verif/status_led_pattern_engine_core_tb.sv
// Self-checking testbench for the status LED pattern engine core.
`timescale 1ns / 1ps
module status_led_pattern_engine_core_tb;
  import slpe_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 9;
  localparam int TOTAL_ITEMS  = 1950;
  localparam int QUIET_ITEMS  = 200;
  localparam int LONG_HOLD    = 400;
  localparam int CYCLE_LIMIT  = 600000;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd5;

  // Brightness scale per even pulse frame, entry 0 is the rightmost byte.
  localparam logic [49:0][7:0] PULSE_SCALE = {
    8'd111, 8'd95,  8'd80,  8'd66,  8'd52,  8'd40,  8'd29,  8'd19,  8'd12,  8'd6,
    8'd2,   8'd0,   8'd0,   8'd2,   8'd6,   8'd12,  8'd20,  8'd29,  8'd40,  8'd52,
    8'd66,  8'd81,  8'd96,  8'd112, 8'd128, 8'd144, 8'd160, 8'd175, 8'd189, 8'd203,
    8'd215, 8'd226, 8'd236, 8'd243, 8'd249, 8'd253, 8'd255, 8'd255, 8'd253, 8'd249,
    8'd243, 8'd236, 8'd226, 8'd215, 8'd203, 8'd189, 8'd175, 8'd159, 8'd144, 8'd128
  };

  typedef struct packed {
    rgb_t color;
    logic refresh;
  } pixel_word_t;

  logic                  clk     = 1'b0;
  logic                  rst     = 1'b1;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [ADDR_W-1:0]     paddr   = '0;
  logic [DATA_W-1:0]     pwdata  = '0;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  logic [ELAPSED_W-1:0]  elapsed_ms = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [COLOR_W-1:0]    pixel_red;
  logic [COLOR_W-1:0]    pixel_green;
  logic [COLOR_W-1:0]    pixel_blue;
  logic                  refresh;

  status_led_pattern_engine_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .elapsed_ms   (elapsed_ms),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .pixel_red    (pixel_red),
    .pixel_green  (pixel_green),
    .pixel_blue   (pixel_blue),
    .refresh      (refresh)
  );

  always #CLK_HALF clk = ~clk;

  logic [ELAPSED_W-1:0] elapsed_pending_q[$];
  pixel_word_t          pixel_expect_q[$];

  int  sent_cnt      = 0;
  int  accepted_cnt  = 0;
  int  items_queued  = 0;
  int  data_errors   = 0;
  int  cfg_errors    = 0;
  int  refresh_cnt   = 0;
  int  result_cnt    = 0;
  int  cfg_writes    = 0;
  int  cycle_cnt     = 0;
  bit  quiet         = 1'b0;
  bit  long_hold_go  = 1'b0;

  // Pattern predictor state.
  logic [MODE_W-1:0]  pm_mode;
  rgb_t               pm_color;
  rgb_t               pm_shown;
  int                 pm_count;
  logic [FRAME_W-1:0] pm_frame;

  function automatic int interval_of(input logic [MODE_W-1:0] mode);
    case (mode)
      MODE_BLINK:   return int'(INTV_BLINK);
      MODE_PULSE:   return int'(INTV_PULSE);
      MODE_RAINBOW: return int'(INTV_RAINBOW);
      MODE_CHASE:   return int'(INTV_CHASE);
      default:      return int'(INTV_NONE);
    endcase
  endfunction

  function automatic rgb_t wheel_color(input logic [FRAME_W-1:0] pos);
    int   p;
    rgb_t c;
    p = int'(COLOR_FULL) - int'(pos);
    if (p < int'(WHEEL_THIRD)) begin
      c.red   = 8'(int'(COLOR_FULL) - 3 * p);
      c.green = '0;
      c.blue  = 8'(3 * p);
    end else if (p < int'(WHEEL_TWOTHIRD)) begin
      p = p - int'(WHEEL_THIRD);
      c.red   = '0;
      c.green = 8'(3 * p);
      c.blue  = 8'(int'(COLOR_FULL) - 3 * p);
    end else begin
      p = p - int'(WHEEL_TWOTHIRD);
      c.red   = 8'(3 * p);
      c.green = 8'(int'(COLOR_FULL) - 3 * p);
      c.blue  = '0;
    end
    return c;
  endfunction

  // Advance the pattern by one elapsed-time transaction and return the pixel word.
  task automatic next_pixel(input logic [ELAPSED_W-1:0] ms, output pixel_word_t w);
    int intv;
    int s;
    pm_count = pm_count + int'(ms);
    if (pm_count > int'(COUNT_MAX)) pm_count = int'(COUNT_MAX);
    intv = interval_of(pm_mode);
    w.refresh = 1'b0;
    if (pm_mode == MODE_SOLID) begin
      pm_shown = pm_color;
    end else if (intv != 0 && pm_count >= intv) begin
      pm_count  = 0;
      w.refresh = 1'b1;
      case (pm_mode)
        MODE_BLINK: begin
          pm_frame = (pm_frame != 0) ? 8'd0 : 8'd1;
          pm_shown = (pm_frame != 0) ? pm_color : '0;
        end
        MODE_PULSE: begin
          pm_frame = 8'((int'(pm_frame) + int'(PULSE_STEP)) % int'(PULSE_FRAMES));
          s = int'(PULSE_SCALE[pm_frame >> 1]);
          pm_shown.red   = 8'((int'(pm_color.red) * s) >> 8);
          pm_shown.green = 8'((int'(pm_color.green) * s) >> 8);
          pm_shown.blue  = 8'((int'(pm_color.blue) * s) >> 8);
        end
        MODE_RAINBOW: begin
          pm_frame = pm_frame + RAINBOW_STEP;
          pm_shown = wheel_color(pm_frame);
        end
        default: begin
          pm_frame = (pm_frame == CHASE_LAST) ? 8'd0 : pm_frame + 8'd1;
          pm_shown = (pm_frame % 3 == 0) ? pm_color : '0;
        end
      endcase
    end
    w.color = pm_shown;
  endtask

  // Monitor: track register writes, check results, predict accepted transactions.
  always @(posedge clk) begin
    pixel_word_t w;
    pixel_word_t exp_w;
    if (rst) begin
      pm_mode  = MODE_SOLID;
      pm_color = '0;
      pm_shown = '0;
      pm_count = 0;
      pm_frame = '0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        cfg_writes++;
        case (paddr[ADDR_W-1:2])
          REG_PATTERN: begin
            pm_mode  = pwdata[MODE_W-1:0];
            pm_frame = '0;
            pm_count = 0;
          end
          REG_RED:   pm_color.red   = pwdata[COLOR_W-1:0];
          REG_GREEN: pm_color.green = pwdata[COLOR_W-1:0];
          REG_BLUE:  pm_color.blue  = pwdata[COLOR_W-1:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        result_cnt++;
        if (refresh) refresh_cnt++;
        if (pixel_expect_q.size() == 0) begin
          $error("result with no pending expectation");
          data_errors++;
        end else begin
          exp_w = pixel_expect_q.pop_front();
          if (pixel_red !== exp_w.color.red) begin
            $error("pixel_red: expected %0d, actual %0d", exp_w.color.red, pixel_red);
            data_errors++;
          end
          if (pixel_green !== exp_w.color.green) begin
            $error("pixel_green: expected %0d, actual %0d", exp_w.color.green, pixel_green);
            data_errors++;
          end
          if (pixel_blue !== exp_w.color.blue) begin
            $error("pixel_blue: expected %0d, actual %0d", exp_w.color.blue, pixel_blue);
            data_errors++;
          end
          if (refresh !== exp_w.refresh) begin
            $error("refresh: expected %0d, actual %0d", exp_w.refresh, refresh);
            data_errors++;
          end
        end
      end
      if (item_valid && !item_stall) begin
        next_pixel(elapsed_ms, w);
        pixel_expect_q.push_back(w);
        accepted_cnt++;
      end
    end
  end

  // Driver: offer pending transactions with random gaps.
  always @(negedge clk) begin
    int gap;
    if (rst) begin
      item_valid <= 1'b0;
      gap = 0;
    end else if (accepted_cnt == sent_cnt) begin
      if (gap > 0) begin
        gap--;
        item_valid <= 1'b0;
      end else if (elapsed_pending_q.size() != 0) begin
        elapsed_ms <= elapsed_pending_q.pop_front();
        item_valid <= 1'b1;
        sent_cnt++;
        if (!quiet && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 15);
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Result consumer: random stall bursts plus one long hold-off.
  always @(negedge clk) begin
    int  burst;
    int  hold_cnt;
    bit  hold_done;
    if (rst) begin
      result_stall <= 1'b0;
      burst     = 0;
      hold_cnt  = 0;
      hold_done = 1'b0;
    end else if (long_hold_go && !hold_done) begin
      result_stall <= 1'b1;
      hold_cnt++;
      if (hold_cnt >= LONG_HOLD) hold_done = 1'b1;
    end else if (quiet) begin
      result_stall <= 1'b0;
    end else if (burst > 0) begin
      burst--;
      result_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      burst = $urandom_range(1, 15) - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("end of test: mismatches");
      $finish;
    end
  end

  logic [DATA_W-1:0] reg_shadow [4];

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_shadow[idx] = val;
  endtask

  task automatic reg_check(input logic [REG_IDX_W-1:0] idx);
    logic [DATA_W-1:0] got;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== reg_shadow[idx]) begin
      $error("prdata: expected %0d, actual %0d", reg_shadow[idx], got);
      cfg_errors++;
    end
  endtask

  task automatic set_pattern(input logic [MODE_W-1:0] mode, input logic [COLOR_W-1:0] r,
                             input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] b);
    reg_write(REG_RED, DATA_W'(r));
    reg_write(REG_GREEN, DATA_W'(g));
    reg_write(REG_BLUE, DATA_W'(b));
    reg_write(REG_PATTERN, DATA_W'(mode));
  endtask

  task automatic offer(input int ms);
    elapsed_pending_q.push_back(ELAPSED_W'(ms));
    items_queued++;
  endtask

  // Hold until every offered transaction has its result back.
  task automatic wait_drained();
    do @(negedge clk);
    while (elapsed_pending_q.size() != 0 || sent_cnt != accepted_cnt ||
           pixel_expect_q.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  function automatic logic [COLOR_W-1:0] pick_color();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return COLOR_FULL;
      default: return COLOR_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return MODE_SOLID;
    if (r < 30) return MODE_BLINK;
    if (r < 50) return MODE_PULSE;
    if (r < 70) return MODE_RAINBOW;
    if (r < 90) return MODE_CHASE;
    return MODE_W'($urandom_range(int'(MODE_UNUSED), 7));
  endfunction

  // Mostly frame-sized steps and sub-interval ticks, some full-range noise.
  function automatic int pick_elapsed(input logic [MODE_W-1:0] mode);
    int intv;
    int r;
    intv = interval_of(mode);
    r = $urandom_range(0, 99);
    if (intv == 0 || r >= 80) return $urandom_range(0, 1023);
    if (r < 45) return intv + $urandom_range(0, 15);
    return $urandom_range(0, intv / 2);
  endfunction

  initial begin
    int phase_cnt;
    int n;
    logic [MODE_W-1:0] mode;
    phase_cnt = 0;
    for (int i = 0; i < 4; i++) reg_shadow[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset state: solid black.
    offer(0);
    offer(1023);
    wait_drained();
    for (int i = 0; i < 4; i++) reg_check(REG_IDX_W'(i));

    // Solid full white, counter driven into saturation.
    set_pattern(MODE_SOLID, COLOR_FULL, COLOR_FULL, COLOR_FULL);
    offer(1023); offer(1023); offer(1023); offer(1);
    wait_drained();
    // Blink: just below, at and far past the interval.
    set_pattern(MODE_BLINK, COLOR_FULL, 8'd0, 8'd128);
    offer(499); offer(1); offer(500); offer(0); offer(1023);
    wait_drained();
    set_pattern(MODE_PULSE, COLOR_FULL, COLOR_FULL, COLOR_FULL);
    offer(49); offer(1); offer(50); offer(50);
    wait_drained();
    set_pattern(MODE_RAINBOW, 8'd0, 8'd0, 8'd0);
    offer(50); offer(25); offer(25); offer(1023);
    wait_drained();
    set_pattern(MODE_CHASE, 8'd1, 8'd2, 8'd3);
    offer(99); offer(1); offer(100); offer(100); offer(100);
    wait_drained();
    // Unused pattern code holds the last colour.
    set_pattern(MODE_UNUSED, 8'd9, 8'd9, 8'd9);
    offer(1023); offer(7);
    wait_drained();
    for (int i = 0; i < 4; i++) reg_check(REG_IDX_W'(i));

    while (items_queued < TOTAL_ITEMS) begin
      if ($urandom_range(0, 1)) reg_write(REG_RED, DATA_W'(pick_color()));
      if ($urandom_range(0, 1)) reg_write(REG_GREEN, DATA_W'(pick_color()));
      if ($urandom_range(0, 1)) reg_write(REG_BLUE, DATA_W'(pick_color()));
      if ($urandom_range(0, 3) != 0) reg_write(REG_PATTERN, DATA_W'(pick_mode()));
      mode = reg_shadow[REG_PATTERN][MODE_W-1:0];
      n = $urandom_range(20, 120);
      if ((mode == MODE_PULSE || mode == MODE_RAINBOW) && $urandom_range(0, 3) == 0) n = 300;
      if (TOTAL_ITEMS - items_queued <= QUIET_ITEMS) begin
        quiet = 1'b1;
        n = TOTAL_ITEMS - items_queued;
      end else if (TOTAL_ITEMS - items_queued - n < QUIET_ITEMS) begin
        n = TOTAL_ITEMS - items_queued - QUIET_ITEMS;
      end
      if (phase_cnt == 3) long_hold_go = 1'b1;
      for (int i = 0; i < n; i++) offer(pick_elapsed(mode));
      wait_drained();
      phase_cnt++;
    end

    repeat (4) @(negedge clk);
    $display("covered %0d transactions (%0d with refresh), %0d register writes, %0d phases",
             result_cnt, refresh_cnt, cfg_writes, phase_cnt);
    if (data_errors + cfg_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d result and %0d register errors", data_errors, cfg_errors);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
